FILE: src/assert_macros.svh
// Assertion macros shared by the route table RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/lpr_pkg.sv
// Package for the IPv6 longest prefix route table: codes, types, helpers.
// No dependencies.
package lpr_pkg;
  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned IfaceBitsDef  = 8;
  localparam int unsigned AddrBits      = 128;
  localparam int unsigned LenBits       = 8;
  localparam int unsigned HopBits       = 128;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_SHIFT  = 6'b000100,
    ST_FETCH  = 6'b001000,
    ST_WRITE  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  // true when the first len bits of a and b agree and len is at most 128
  function automatic logic prefix_hit(input logic [AddrBits-1:0] a,
                                      input logic [AddrBits-1:0] b,
                                      input logic [LenBits-1:0] len);
    logic [AddrBits-1:0] m;
    m = '1;
    if (len > LenBits'(AddrBits)) return 1'b0;
    if (len == '0) return 1'b1;
    m = m << (AddrBits - 32'(len));
    return ((a ^ b) & m) == '0;
  endfunction
endpackage

FILE: src/lpr_mem.sv
// Route entry storage: one synchronous memory, one write and one read port.
// Depends on lpr_pkg.
module lpr_mem import lpr_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned IfaceBits  = IfaceBitsDef,
  localparam int unsigned Aw = $clog2(TableDepth),
  localparam int unsigned Ew = AddrBits + LenBits + HopBits + IfaceBits
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [Ew-1:0] wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [Ew-1:0] rdata_o
);
  logic [Ew-1:0] mem_q [TableDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: src/ipv6_longest_prefix_route_table.sv
// IPv6 longest prefix route table top: sequencer around the entry memory.
// Depends on lpr_pkg, lpr_mem, assert_macros.svh.
//
//  channel | signals                                   | dir
//  in      | in_valid_i, in_stall_o, operation_i ...   | into block
//  out     | out_valid_o, out_stall_i, found_o ...     | out of block
//
// One word in flight; an operation scans the used entries, one memory read a cycle.
// The result is valid once the scan ends; the next word is taken only after the result
// is taken. A hit stops an insert/delete scan early; a delete hit then moves each
// later entry down one slot through the shift, fetch and write states.
// Reset empties the table at once (used count cleared); no clearing pass.
// Input stalls while a word is in work or a result waits to be taken.
`include "assert_macros.svh"
module ipv6_longest_prefix_route_table import lpr_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned IfaceBits  = IfaceBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] addr_high_i,
  input  logic [63:0] addr_low_i,
  input  logic [7:0]  prefix_len_i,
  input  logic [63:0] hop_high_i,
  input  logic [63:0] hop_low_i,
  input  logic [7:0]  iface_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [63:0] out_hop_high_o,
  output logic [63:0] out_hop_low_o,
  output logic [7:0]  out_iface_o,
  output logic        status_o
);
  localparam int unsigned Aw = $clog2(TableDepth);
  localparam int unsigned Cw = $clog2(TableDepth + 1);
  localparam int unsigned Ew = AddrBits + LenBits + HopBits + IfaceBits;

  state_e state_q, state_d;
  op_e op_q;
  logic [AddrBits-1:0] addr_q;
  logic [LenBits-1:0] len_q;
  logic [HopBits-1:0] hop_q;
  logic [IfaceBits-1:0] ifc_q;
  logic [Cw-1:0] used_q, used_d;
  logic [Cw-1:0] idx_q, idx_d;
  logic [Cw-1:0] rd_q;
  logic rd_vld_q;
  logic any_q, any_d;
  logic [Aw-1:0] best_q, best_d;
  logic [LenBits-1:0] blen_q, blen_d;
  logic [HopBits-1:0] bhop_q, bhop_d;
  logic [IfaceBits-1:0] bifc_q, bifc_d;

  logic we;
  logic [Aw-1:0] waddr, raddr;
  logic [Ew-1:0] wdata, rdata;

  logic [AddrBits-1:0] r_addr;
  logic [LenBits-1:0] r_len;
  logic [HopBits-1:0] r_hop;
  logic [IfaceBits-1:0] r_ifc;
  assign {r_addr, r_len, r_hop, r_ifc} = rdata;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || out_valid_o;

  logic out_v_q, found_q, status_q;
  logic [HopBits-1:0] ohop_q;
  logic [IfaceBits-1:0] oifc_q;

  lpr_mem #(.TableDepth(TableDepth), .IfaceBits(IfaceBits)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic exact, lhit, fin;
  assign exact = rd_vld_q && r_addr == addr_q && r_len == len_q;
  assign lhit  = rd_vld_q && prefix_hit(r_addr, addr_q, r_len);
  assign fin   = 1'b0;

  logic done_d, found_d, status_d;
  logic [HopBits-1:0] ohop_d;
  logic [IfaceBits-1:0] oifc_d;

  always_comb begin
    state_d = state_q; used_d = used_q; idx_d = idx_q;
    any_d = any_q; best_d = best_q; blen_d = blen_q;
    bhop_d = bhop_q; bifc_d = bifc_q;
    we = 1'b0; waddr = '0; wdata = {addr_q, len_q, hop_q, ifc_q};
    raddr = idx_q[Aw-1:0];
    done_d = 1'b0; found_d = 1'b0; status_d = 1'b0; ohop_d = '0; oifc_d = '0;
    unique case (state_q)
      ST_IDLE: begin
        raddr = '0;
        idx_d = '0;
        any_d = 1'b0; blen_d = '0;
      end
      ST_SCAN: begin
        // idx_q is the address issued this cycle; rd_q the entry arriving
        if (idx_q < used_q) idx_d = idx_q + 1'b1;
        if (op_q == OP_LOOKUP) begin
          if (lhit && (!any_q || r_len > blen_q)) begin
            any_d = 1'b1; best_d = rd_q[Aw-1:0]; blen_d = r_len;
            bhop_d = r_hop; bifc_d = r_ifc;
          end
          if (!rd_vld_q && idx_q >= used_q && idx_q != '0 || used_q == '0)
            state_d = ST_DONE;
          else if (rd_vld_q && rd_q + 1'b1 >= used_q) state_d = ST_DONE;
        end else if (exact) begin
          if (op_q == OP_INSERT) begin
            we = 1'b1; waddr = rd_q[Aw-1:0];
            state_d = ST_DONE;
          end else begin
            found_d = 1'b1;
            idx_d = rd_q + 1'b1;
            state_d = ST_SHIFT;
          end
        end else if (used_q == '0 || (rd_vld_q && rd_q + 1'b1 >= used_q)) begin
          state_d = ST_DONE;
          if (op_q == OP_INSERT) begin
            if (used_q == Cw'(TableDepth)) status_d = 1'b1;
            else begin
              we = 1'b1; waddr = used_q[Aw-1:0]; used_d = used_q + 1'b1;
            end
          end
        end
        if (state_d == ST_DONE && !(op_q == OP_DELETE && exact)) begin
          done_d = 1'b1;
          if (op_q == OP_LOOKUP) begin
            found_d = any_d; ohop_d = any_d ? bhop_d : '0;
            oifc_d = any_d ? bifc_d : '0;
          end
        end
      end
      ST_SHIFT: begin
        // idx_q: source entry to move down one slot
        if (idx_q >= used_q) begin
          used_d = used_q - 1'b1;
          done_d = 1'b1; found_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_WRITE;
      ST_WRITE: begin
        we = 1'b1; waddr = Aw'(idx_q - 1'b1); wdata = rdata;
        idx_d = idx_q + 1'b1;
        state_d = ST_SHIFT;
      end
      ST_DONE: if (!out_v_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_IDLE && in_acc) begin
      state_d = (operation_i == OP_NONE) ? ST_DONE : ST_SCAN;
      done_d = (operation_i == OP_NONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; used_q <= '0; idx_q <= '0; rd_vld_q <= 1'b0;
      rd_q <= '0; any_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; used_q <= used_d; idx_q <= idx_d; any_q <= any_d;
      rd_vld_q <= (state_q == ST_SCAN) && (idx_q < used_q) && (state_d == ST_SCAN);
      rd_q <= idx_q;
      if (done_d) out_v_q <= 1'b1;
      else if (out_acc) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d; blen_q <= blen_d; bhop_q <= bhop_d; bifc_q <= bifc_d;
    if (in_acc) begin
      op_q <= op_e'(operation_i); addr_q <= {addr_high_i, addr_low_i};
      len_q <= prefix_len_i; hop_q <= {hop_high_i, hop_low_i};
      ifc_q <= IfaceBits'(iface_i);
    end
    if (done_d) begin
      found_q <= found_d; status_q <= status_d; ohop_q <= ohop_d; oifc_q <= oifc_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign found_o        = found_q | fin;
  assign status_o       = status_q;
  assign out_hop_high_o = ohop_q[127:64];
  assign out_hop_low_o  = ohop_q[63:0];
  assign out_iface_o    = 8'(oifc_q);

  `ASSERT_IMPL(a_used_range, clk_i, rst_ni, 1'b1, used_q <= Cw'(TableDepth))
  `ASSERT_IMPL(a_no_acc_busy, clk_i, rst_ni, state_q != ST_IDLE, !in_acc)
  `ASSERT_NEXT(a_full_no_grow, clk_i, rst_ni, used_q == Cw'(TableDepth) && we &&
               state_q == ST_SCAN, used_q == Cw'(TableDepth))
endmodule

FILE: bench/tb_ipv6_longest_prefix_route_table.sv
// Testbench for ipv6_longest_prefix_route_table: directed and random insert/delete/lookup words
// checked against a behavioral route table predictor. Depends on lpr_pkg and the RTL.
`timescale 1ns / 100ps
module tb_ipv6_longest_prefix_route_table import lpr_pkg::*; ();

  localparam int Depth = 64;
  localparam int WatchdogLimit = 20000;

  typedef struct {
    op_e          op;
    logic [63:0]  ah, al;
    logic [7:0]   len;
    logic [63:0]  hh, hl;
    logic [7:0]   ifc;
    bit           hold;
  } word_t;

  typedef struct {
    logic        found;
    logic [63:0] hh, hl;
    logic [7:0]  ifc;
    logic        status;
  } route_res_t;

  typedef struct {
    logic [63:0] ah, al;
    logic [7:0]  len;
    logic [63:0] hh, hl;
    logic [7:0]  ifc;
  } route_t;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_stall_o, out_valid_o, out_stall_i = 0;
  logic [1:0] operation_i = '0;
  logic [63:0] addr_high_i = '0, addr_low_i = '0, hop_high_i = '0, hop_low_i = '0;
  logic [7:0] prefix_len_i = '0, iface_i = '0;
  logic found_o, status_o;
  logic [63:0] out_hop_high_o, out_hop_low_o;
  logic [7:0] out_iface_o;

  ipv6_longest_prefix_route_table DUT (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  word_t pending_words[$];
  route_res_t expected_routes[$];
  route_t routes[$];
  route_t known_prefixes[$];
  int errors = 0, in_gap = 0, out_gap = 0, idle_cycles = 0;
  bit stim_done = 0, holding = 0, in_taken = 0;

  function automatic bit prefix_match(route_t r, logic [63:0] ah, logic [63:0] al);
    logic [127:0] m;
    if (r.len > 128) return 0;
    if (r.len == 0) return 1;
    m = {128{1'b1}} << (128 - r.len);
    return ((({r.ah, r.al}) ^ {ah, al}) & m) == '0;
  endfunction

  function automatic route_res_t route_predict(word_t w);
    route_res_t res;
    route_t r;
    int hit, best;
    res = '{default: '0};
    hit = -1;
    best = -1;
    foreach (routes[i])
      if (hit < 0 && routes[i].ah == w.ah && routes[i].al == w.al && routes[i].len == w.len)
        hit = i;
    unique case (w.op)
      OP_INSERT: begin
        if (hit >= 0) begin
          routes[hit].hh = w.hh;
          routes[hit].hl = w.hl;
          routes[hit].ifc = w.ifc;
        end else if (routes.size() >= Depth) begin
          res.status = 1;
        end else begin
          r = '{w.ah, w.al, w.len, w.hh, w.hl, w.ifc};
          routes = {routes, r};
        end
      end
      OP_DELETE: if (hit >= 0) begin
        routes.delete(hit);
        res.found = 1;
      end
      OP_LOOKUP: begin
        foreach (routes[i])
          if (prefix_match(routes[i], w.ah, w.al) &&
              (best < 0 || routes[i].len > routes[best].len))
            best = i;
        if (best >= 0) begin
          res.found = 1;
          res.hh = routes[best].hh;
          res.hl = routes[best].hl;
          res.ifc = routes[best].ifc;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic word_t rand_word(op_e op);
    word_t w;
    route_t p;
    w.op = op;
    w.hold = 0;
    w.hh = rand64();
    w.hl = rand64();
    w.ifc = 8'($urandom());
    w.len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(129, 255))
                                         : 8'($urandom_range(0, 128));
    w.ah = rand64();
    w.al = rand64();
    if (known_prefixes.size() > 0 && $urandom_range(0, 3) != 0) begin
      p = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
      if (op != OP_LOOKUP || $urandom_range(0, 3) == 0) begin
        w.ah = p.ah;
        w.al = p.al;
        w.len = p.len;
      end else begin
        // keep the prefix bits, randomize the tail
        w.ah = (p.len >= 64) ? p.ah : ((p.ah & ~(64'hFFFF_FFFF_FFFF_FFFF >> p.len)) |
               (w.ah & (64'hFFFF_FFFF_FFFF_FFFF >> p.len)));
        w.al = (p.len >= 128) ? p.al : (p.len <= 64) ? w.al :
               ((p.al & ~(64'hFFFF_FFFF_FFFF_FFFF >> (p.len - 64))) |
               (w.al & (64'hFFFF_FFFF_FFFF_FFFF >> (p.len - 64))));
      end
    end
    if (op == OP_INSERT && known_prefixes.size() < 40) begin
      p = '{w.ah, w.al, w.len, '0, '0, '0};
      known_prefixes = {known_prefixes, p};
    end
    return w;
  endfunction

  function automatic void add_word(op_e op, logic [63:0] ah, logic [63:0] al,
                                   logic [7:0] len, logic [63:0] h, logic [7:0] ifc);
    word_t w;
    w = '{op, ah, al, len, h, ~h, ifc, 0};
    pending_words = {pending_words, w};
  endfunction

  initial begin
    word_t w;
    int r;
    op_e op;
    add_word(OP_LOOKUP, '0, '0, 0, '0, 0);
    add_word(OP_DELETE, '0, '0, 0, '0, 0);
    add_word(OP_INSERT, '0, '0, 0, 64'h1, 8'h01);
    add_word(OP_INSERT, '1, '1, 128, '1, 8'hFF);
    add_word(OP_INSERT, 64'hFFFF_0000_0000_0000, '0, 16, 64'h2, 8'h02);
    add_word(OP_INSERT, 64'hFFFF_0000_0000_0000, '0, 16, 64'h3, 8'h03);
    add_word(OP_INSERT, 64'hFFFF_0000_0000_0000, '1, 16, 64'h4, 8'h04);
    add_word(OP_INSERT, '1, '1, 200, 64'h5, 8'h05);
    add_word(OP_INSERT, '1, '0, 64, 64'h6, 8'h06);
    add_word(OP_INSERT, '1, 64'h8000_0000_0000_0000, 65, 64'h7, 8'h07);
    add_word(OP_LOOKUP, '1, '1, 0, '0, 0);
    add_word(OP_LOOKUP, '1, 64'h8000_0000_0000_0001, 0, '0, 0);
    add_word(OP_LOOKUP, 64'hFFFF_1234_0000_0000, '0, 0, '0, 0);
    add_word(OP_LOOKUP, 64'h1234_0000_0000_0000, '0, 0, '0, 0);
    add_word(OP_NONE, '1, '1, 8'hFF, '1, 8'hFF);
    add_word(OP_DELETE, '1, '1, 200, '0, 0);
    add_word(OP_DELETE, '1, '1, 201, '0, 0);
    add_word(OP_DELETE, '0, '0, 0, '0, 0);
    add_word(OP_LOOKUP, 64'h1234_0000_0000_0000, '0, 0, '0, 0);
    add_word(OP_DELETE, '1, '1, 128, '0, 0);
    add_word(OP_LOOKUP, '1, '1, 0, '0, 0);
    // fill the table past full, update while full, then drain
    for (int i = 0; i < 70; i++)
      add_word(OP_INSERT, 64'(i), 64'(i * 3), 8'(i % 129), rand64(), 8'(i));
    add_word(OP_INSERT, 64'(5), 64'(15), 8'(5), 64'hABCD, 8'hAA);
    add_word(OP_LOOKUP, 64'(5), 64'(15), 0, '0, 0);
    for (int i = 0; i < 70; i++)
      add_word(OP_DELETE, 64'(i), 64'(i * 3), 8'(i % 129), '0, 0);
    for (int i = 0; i < 1700; i++) begin
      r = $urandom_range(0, 99);
      op = (r < 40) ? OP_INSERT : (r < 60) ? OP_DELETE : (r < 97) ? OP_LOOKUP : OP_NONE;
      w = rand_word(op);
      if (i == 800) w.hold = 1;
      if (i % 400 == 399) known_prefixes.delete();
      pending_words = {pending_words, w};
    end
    stim_done = 1;
  end

  // input accept: take the word and predict its result
  always @(posedge clk_i) begin
    word_t w;
    route_res_t e;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      w = pending_words.pop_front();
      e = route_predict(w);
      expected_routes = {expected_routes, e};
      in_taken = 1;
    end
  end

  // driver
  always @(negedge clk_i) begin
    word_t w;
    if (rst_ni) begin
      if (in_taken) begin
        in_taken = 0;
        in_valid_i <= 0;
        in_gap <= $urandom_range(0, 6);
      end else if (!in_valid_i && pending_words.size() > 0) begin
        if (pending_words[0].hold && !holding && expected_routes.size() > 0) begin
          holding <= 1;
        end else if (holding && expected_routes.size() > 0) begin
        end else if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else begin
          holding <= 0;
          w = pending_words[0];
          operation_i <= w.op;
          addr_high_i <= w.ah;
          addr_low_i <= w.al;
          prefix_len_i <= w.len;
          hop_high_i <= w.hh;
          hop_low_i <= w.hl;
          iface_i <= w.ifc;
          in_valid_i <= 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    route_res_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_routes.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          e = expected_routes.pop_front();
          if (found_o !== e.found) begin
            $error("found: expected %0h actual %0h", e.found, found_o); errors++;
          end
          if (out_hop_high_o !== e.hh) begin
            $error("out_hop_high: expected %0h actual %0h", e.hh, out_hop_high_o); errors++;
          end
          if (out_hop_low_o !== e.hl) begin
            $error("out_hop_low: expected %0h actual %0h", e.hl, out_hop_low_o); errors++;
          end
          if (out_iface_o !== e.ifc) begin
            $error("out_iface: expected %0h actual %0h", e.ifc, out_iface_o); errors++;
          end
          if (status_o !== e.status) begin
            $error("status: expected %0h actual %0h", e.status, status_o); errors++;
          end
        end
        out_gap <= $urandom_range(0, 6);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // stall the output while out_gap counts down after each accepted result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_stall_i <= 1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall_i <= 0;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;
    wait (stim_done && pending_words.size() == 0 && !in_valid_i &&
          expected_routes.size() == 0 || idle_cycles >= WatchdogLimit);
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      repeat (100) @(posedge clk_i);
      if (errors == 0 && expected_routes.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
    end
  end
endmodule
